/* rtl/nau_pkg.sv */
// Shared types and constants for the neural activation unit.
package nau_pkg;

    // Function codes held in the selector register
    typedef enum logic [2:0] {
        FN_RELU    = 3'd0,
        FN_GELU    = 3'd1,
        FN_SWISH   = 3'd2,
        FN_SIGMOID = 3'd3,
        FN_TANH    = 3'd4
    } t_func;

    localparam int SAMPLE_W = 16;
    localparam int SEL_W    = 3;

    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] T_MAX   = 64'h0400_0000_0000_0000;
    localparam logic [20:0] MILLION = 21'd1000000;

    // One pipeline slot: control fields plus working values
    typedef struct packed {
        logic                last;
        logic [SEL_W-1:0]    sel;
        logic                neg;
        logic [15:0]         mag;
        logic [SAMPLE_W-1:0] smp;
        logic [58:0]         targ;
        logic [63:0]         term;
        logic [63:0]         sum;
        logic [63:0]         quo;
        logic [63:0]         rem;
        logic [3:0][63:0]    pp;
    } t_work;

    // Finished result handed to the output buffer
    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } t_result;

endpackage

/* rtl/neural_activation_unit.sv */
// Top level of the activation unit: selector register, pipeline and output buffer.
// Throughput: one transaction per cycle; the 143-stage pipeline advances whenever
// the two-entry output buffer has room, so input stalls only when both entries wait.
// Reset (i_rst_n low, synchronous): empties pipeline and buffer, selector returns to ReLU.
// The exp series (12 terms, 4 stages each) and the 62-stage restoring divide set the depth.
module neural_activation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nau_pkg::SEL_W-1:0]     i_cfg_data,     // function_select
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [nau_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
    input  logic                          s_axis_tlast,   // last_element
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [nau_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
    output logic                          m_axis_tlast    // last_out
);
    import nau_pkg::*;

    logic [SEL_W-1:0] r_sel;
    logic             en;
    logic             dp_valid;
    t_result          dp_result;
    logic             push;
    logic             pop;

    // output buffer: two entries, ring pointers
    t_result          r_buf [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;

    // Selector register: the user must write it only while the unit is idle; the block itself does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= FN_RELU;
        end else if (i_cfg_valid) begin
            r_sel <= i_cfg_data;
        end
    end

    // Advance the whole pipeline while the buffer is not full
    assign en            = (r_cnt != 2'd2);
    assign s_axis_tready = en;

    nau_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_sel    (r_sel),
        .o_valid  (dp_valid),
        .o_result (dp_result)
    );

    // Drop the finished item into the buffer as it leaves the last stage
    assign push = en && dp_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= dp_result;
        end
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_buf[r_rd_ptr].sample;
    assign m_axis_tlast  = r_buf[r_rd_ptr].last;

    // Buffer never holds more than two transactions
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    // Simultaneous push and pop leaves the fill unchanged
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && pop) |=> $stable(r_cnt))
        else $error("buffer count moved on push with pop");

    // Pointers differ exactly when the buffer holds one entry
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr != r_rd_ptr) == (r_cnt == 2'd1))
        else $error("buffer pointers disagree with count");

    // A full buffer that is not read keeps the pipeline stalled in the next cycle
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> !s_axis_tready)
        else $error("pipeline advanced into a full buffer");

endmodule

/* rtl/nau_datapath.sv */
// Pipelined datapath of the activation unit: argument, exp series, repeated squaring, sigmoid divide, scaling.
module nau_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [nau_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_last,
    input  logic [nau_pkg::SEL_W-1:0]     i_sel,
    output logic                          o_valid,
    output nau_pkg::t_result              o_result
);
    import nau_pkg::*;

    localparam int S_ABS  = 1;
    localparam int S_SQA  = 2;
    localparam int S_CUBE = 3;
    localparam int S_C3   = 4;
    localparam int S_N    = 5;
    localparam int S_DM0  = 6;
    localparam int S_DM1  = S_DM0 + 1;
    localparam int DM_N   = 2;
    localparam int S_TS   = S_DM0 + DM_N;
    localparam int S_EX0  = S_TS + 1;
    localparam int EX_N   = 48;
    localparam int S_SQ0  = S_EX0 + EX_N;
    localparam int SQ_N   = 20;
    localparam int S_SD   = S_SQ0 + SQ_N;
    localparam int S_DV0  = S_SD + 1;
    localparam int DV_N   = 62;
    localparam int S_F1   = S_DV0 + DV_N;
    localparam int S_F2   = S_F1 + 1;
    localparam int S_F3   = S_F2 + 1;
    localparam int NS     = S_F3 + 1;

    // n * 2^17 / 10^6 = n * 2^11 / 15625 = floor(n * DM_RCP / 2^75) for n < 2^61
    localparam logic [86:0] DM_RCP_W = ((87'd1 << 86) + 87'd15624) / 87'd15625;
    localparam logic [72:0] DM_RCP   = DM_RCP_W[72:0];

    function automatic logic [3:0][63:0] mul_parts(input logic [63:0] a, input logic [63:0] b);
        logic [3:0][63:0] p;
        p[0] = {32'b0, a[31:0]}  * {32'b0, b[31:0]};
        p[1] = {32'b0, a[31:0]}  * {32'b0, b[63:32]};
        p[2] = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        p[3] = {32'b0, a[63:32]} * {32'b0, b[63:32]};
        return p;
    endfunction

    // Q2.62 product, truncated: bits 125..62 of the full product
    function automatic logic [63:0] mul_q62(input logic [3:0][63:0] p);
        logic [127:0] wide;
        wide = {64'b0, p[0]} + {32'b0, p[1], 32'b0} + {32'b0, p[2], 32'b0} + {p[3], 64'b0};
        return wide[125:62];
    endfunction

    // Upper half of the full 128-bit product
    function automatic logic [63:0] mul_hi(input logic [3:0][63:0] p);
        logic [127:0] wide;
        wide = {64'b0, p[0]} + {32'b0, p[1], 32'b0} + {32'b0, p[2], 32'b0} + {p[3], 64'b0};
        return wide[127:64];
    endfunction

    logic [NS-1:0] r_vld;
    t_work         r_st [NS];
    t_work         n_st [NS];

    always_comb begin
        n_st[0]      = '0;
        n_st[0].smp  = i_sample;
        n_st[0].last = i_last;
        n_st[0].sel  = i_sel;
    end

    for (genvar i = 1; i < NS; i++) begin : g_stage
        t_work w_nxt;
        assign n_st[i] = w_nxt;

        if (i == S_ABS) begin : g_abs
            always_comb begin
                w_nxt     = r_st[i-1];
                w_nxt.neg = r_st[i-1].smp[15];
                w_nxt.mag = r_st[i-1].smp[15] ? 16'(-r_st[i-1].smp) : r_st[i-1].smp;
            end
        end else if (i == S_SQA) begin : g_sqa
            always_comb begin
                w_nxt       = r_st[i-1];
                w_nxt.pp[0] = 64'({16'b0, r_st[i-1].mag} * {16'b0, r_st[i-1].mag});
                w_nxt.pp[1] = 64'({19'b0, r_st[i-1].mag} * 35'd797884);
            end
        end else if (i == S_CUBE) begin : g_cube
            always_comb begin
                w_nxt       = r_st[i-1];
                w_nxt.pp[0] = 64'({16'b0, r_st[i-1].pp[0][31:0]} * {32'b0, r_st[i-1].mag});
            end
        end else if (i == S_C3) begin : g_c3
            always_comb begin
                w_nxt       = r_st[i-1];
                w_nxt.pp[0] = 64'({14'b0, r_st[i-1].pp[0][47:0]} * 62'd35677);
            end
        end else if (i == S_N) begin : g_n
            logic [63:0] nsum;
            always_comb begin
                nsum      = {5'b0, r_st[i-1].pp[1][34:0], 24'b0} + r_st[i-1].pp[0];
                w_nxt     = r_st[i-1];
                w_nxt.quo = nsum;
            end
        end else if (i == S_DM0) begin : g_dm0
            // partial products of n * DM_RCP; term and sum carry the top-digit products
            always_comb begin
                w_nxt      = r_st[i-1];
                w_nxt.pp   = mul_parts(r_st[i-1].quo, DM_RCP[63:0]);
                w_nxt.term = 64'({32'b0, r_st[i-1].quo[31:0]} * {55'b0, DM_RCP[72:64]});
                w_nxt.sum  = 64'({32'b0, r_st[i-1].quo[63:32]} * {55'b0, DM_RCP[72:64]});
            end
        end else if (i == S_DM1) begin : g_dm1
            logic [159:0] full;
            always_comb begin
                full = {96'b0, r_st[i-1].pp[0]}
                     + {64'b0, r_st[i-1].pp[1], 32'b0}
                     + {64'b0, r_st[i-1].pp[2], 32'b0}
                     + {32'b0, r_st[i-1].pp[3], 64'b0}
                     + {32'b0, r_st[i-1].term, 64'b0}
                     + {r_st[i-1].sum, 96'b0};
                w_nxt     = r_st[i-1];
                w_nxt.quo = full[138:75];
            end
        end else if (i == S_TS) begin : g_ts
            always_comb begin
                w_nxt      = r_st[i-1];
                w_nxt.term = Q62_ONE;
                w_nxt.sum  = Q62_ONE;
                unique case (r_st[i-1].sel) inside
                    FN_GELU:
                        w_nxt.targ = (r_st[i-1].quo > T_MAX) ? T_MAX[58:0]
                                                              : r_st[i-1].quo[58:0];
                    FN_SWISH, FN_SIGMOID:
                        w_nxt.targ = {3'b0, r_st[i-1].mag, 40'b0};
                    FN_TANH:
                        w_nxt.targ = {2'b0, r_st[i-1].mag, 41'b0};
                    default:
                        w_nxt.targ = '0;
                endcase
            end
        end else if (i >= S_EX0 && i < S_SQ0) begin : g_ex
            localparam int K  = (i - S_EX0) / 4 + 1;
            localparam int PH = (i - S_EX0) % 4;
            // floor(q / K) = (q + hi(q * RCP[63:0])) >> L, where RCP = 2^64 + RCP[63:0]
            localparam int L  = $clog2(K);
            localparam logic [68:0] RCP = ((69'd1 << (64 + L)) + 69'(K) - 69'd1) / 69'(K);
            logic [64:0] qs;
            always_comb begin
                w_nxt = r_st[i-1];
                qs    = '0;
                if (PH == 0) begin
                    w_nxt.pp = mul_parts(r_st[i-1].term, {5'b0, r_st[i-1].targ});
                end else if (PH == 1) begin
                    w_nxt.quo = mul_q62(r_st[i-1].pp);
                end else if (PH == 2) begin
                    w_nxt.pp = mul_parts(r_st[i-1].quo, RCP[63:0]);
                end else begin
                    qs         = {1'b0, r_st[i-1].quo} + {1'b0, mul_hi(r_st[i-1].pp)};
                    w_nxt.term = 64'(qs >> L);
                    w_nxt.sum  = (K % 2 == 1) ? r_st[i-1].sum - w_nxt.term
                                              : r_st[i-1].sum + w_nxt.term;
                end
            end
        end else if (i >= S_SQ0 && i < S_SD) begin : g_sq
            localparam int PH = (i - S_SQ0) % 2;
            always_comb begin
                w_nxt = r_st[i-1];
                if (PH == 0) begin
                    w_nxt.pp = mul_parts(r_st[i-1].sum, r_st[i-1].sum);
                end else begin
                    w_nxt.sum = mul_q62(r_st[i-1].pp);
                end
            end
        end else if (i == S_SD) begin : g_sd
            always_comb begin
                w_nxt      = r_st[i-1];
                w_nxt.term = Q62_ONE + r_st[i-1].sum;
                w_nxt.quo  = (r_st[i-1].sum == '0) ? 64'd1 : 64'd0;
                w_nxt.rem  = (r_st[i-1].sum == '0) ? 64'd0 : Q62_ONE;
            end
        end else if (i >= S_DV0 && i < S_F1) begin : g_dv
            logic [63:0] rs;
            always_comb begin
                w_nxt = r_st[i-1];
                rs    = {r_st[i-1].rem[62:0], 1'b0};
                if (rs >= r_st[i-1].term) begin
                    w_nxt.rem = rs - r_st[i-1].term;
                    w_nxt.quo = {r_st[i-1].quo[62:0], 1'b1};
                end else begin
                    w_nxt.rem = rs;
                    w_nxt.quo = {r_st[i-1].quo[62:0], 1'b0};
                end
            end
        end else if (i == S_F1) begin : g_f1
            logic [63:0] cmp;
            always_comb begin
                w_nxt = r_st[i-1];
                cmp   = Q62_ONE - r_st[i-1].quo;
                unique case (r_st[i-1].sel) inside
                    FN_GELU, FN_SWISH: begin
                        w_nxt.rem = {48'b0, r_st[i-1].mag};
                        w_nxt.quo = r_st[i-1].neg ? cmp : r_st[i-1].quo;
                    end
                    FN_SIGMOID: begin
                        w_nxt.rem = 64'd4096;
                        w_nxt.quo = r_st[i-1].neg ? cmp : r_st[i-1].quo;
                    end
                    FN_TANH: begin
                        w_nxt.rem = 64'd8192;
                        w_nxt.quo = r_st[i-1].quo;
                    end
                    default: begin
                        w_nxt.rem = '0;
                        w_nxt.quo = '0;
                    end
                endcase
            end
        end else if (i == S_F2) begin : g_f2
            always_comb begin
                w_nxt       = r_st[i-1];
                w_nxt.pp[0] = 64'({32'b0, r_st[i-1].rem[15:0]}
                                  * {16'b0, r_st[i-1].quo[63:32]});
                w_nxt.pp[1] = 64'({32'b0, r_st[i-1].rem[15:0]}
                                  * {16'b0, r_st[i-1].quo[31:0]})
                              + 64'h2000_0000_0000_0000;
            end
        end else begin : g_f3
            logic [63:0]        s;
            logic signed [31:0] v;
            logic signed [31:0] th;
            logic signed [31:0] res;
            always_comb begin
                s   = r_st[i-1].pp[0] + {32'b0, r_st[i-1].pp[1][63:32]};
                v   = s[61:30];
                th  = v - 32'sd4096;
                unique case (r_st[i-1].sel) inside
                    FN_RELU:           res = r_st[i-1].neg ? 32'sd0 : {16'b0, r_st[i-1].mag};
                    FN_GELU, FN_SWISH: res = r_st[i-1].neg ? -v : v;
                    FN_SIGMOID:        res = v;
                    FN_TANH:           res = r_st[i-1].neg ? -th : th;
                    default:           res = 32'sd0;
                endcase
                if (res > 32'sd32767) begin
                    res = 32'sd32767;
                end else if (res < -32'sd32768) begin
                    res = -32'sd32768;
                end
                w_nxt     = r_st[i-1];
                w_nxt.smp = res[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid         = r_vld[NS-1];
    assign o_result.last   = r_st[NS-1].last;
    assign o_result.sample = r_st[NS-1].smp;

endmodule
